/* design/assert_macros.svh */
// assertion macros shared by the rtl that checks itself
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define RPN_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RPN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/rpn_pkg.sv */
// shared types and constants of the rpn stack calculator
// no dependencies
`timescale 1ns / 1ps

package rpn_pkg;

    localparam int unsigned DEF_STACK_DEPTH = 16;
    localparam int unsigned DATA_W          = 32;
    localparam int unsigned DEPTH_W         = 5;
    localparam int unsigned STATUS_W        = 3;

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_OP   = 2'd1,
        ACT_END  = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_DIVZERO   = 3'd3,
        ST_MALFORMED = 3'd4
    } status_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quot;
    } div_rsp_t;

endpackage

/* design/rpn_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module rpn_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/rpn_div.sv */
// iterative signed 32-bit divider, one quotient bit per cycle, truncates toward zero
// depends on rpn_pkg
`timescale 1ns / 1ps

module rpn_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rpn_pkg::div_req_t req,
    output rpn_pkg::div_rsp_t rsp
);
    import rpn_pkg::*;

    localparam int unsigned STEP_W = $clog2(DATA_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic              neg_reg, neg_next;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   trial;

    function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
        mag = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
    endfunction

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DATA_W-1]};
        trial     = shifted - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = mag(req.num);
            den_next  = mag(req.den);
            neg_next  = req.num[DATA_W-1] ^ req.den[DATA_W-1];
        end
        else if (busy_reg)
        begin
            // restoring step
            if (!trial[DATA_W])
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = neg_reg ? (~quo_reg + DATA_W'(1)) : quo_reg;

endmodule

/* design/rpn_stack_calculator.sv */
// rpn stack calculator: evaluates integer reverse polish expressions on a bounded stack
// depends on rpn_pkg, rpn_ram, rpn_div and assert_macros.svh
//
// usage:
//   one request in (action, operand, operator_code) gives exactly one result out
//   (top_value, depth, status, final_res). both channels handshake with valid and
//   stall; a transfer happens on a clock edge with valid high and stall low.
//   requests are handled one at a time: in_stall stays high from the accepting edge
//   until the result has moved into the output register.
//   steps from accept to the output register: push, end, unused action, overflow,
//     underflow: decode, output load; add, subtract, multiply: stack read, execute,
//     write back, output load; divide: the same, with the bit-serial divider taking
//     32 steps before write back; divide by zero: stack read, execute, output load
//   the stack entries live in a ram with registered read; the top entry is also
//   kept in a register, so only the entry below it is read from the ram.
//   a finished result sits in the output register while the receiver stalls, and
//   the next request is still taken and worked on meanwhile; it waits before
//   its own output load until the register frees up.
//   reset empties the stack at once (count to zero), no clearing pass is needed;
//   ram contents stay undefined and are never read below an unwritten entry.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rpn_stack_calculator #(
    parameter int unsigned STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic signed [rpn_pkg::DATA_W-1:0] operand,
    input  logic [1:0]                    operator_code,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [rpn_pkg::DATA_W-1:0] top_value,
    output logic [rpn_pkg::DEPTH_W-1:0]   depth,
    output logic [rpn_pkg::STATUS_W-1:0]  status,
    output logic                          final_res
);
    import rpn_pkg::*;

    localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_EXEC   = 6'b000100,
        S_DIV    = 6'b001000,
        S_WB     = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] top_reg, top_next;     // cached top of stack, zero when empty

    // latched request
    action_t           act_reg, act_next;
    logic [DATA_W-1:0] opnd_reg, opnd_next;
    op_t               code_reg, code_next;

    // pending result
    logic [DATA_W-1:0] r_reg, r_next;
    logic [DATA_W-1:0] res_top_reg, res_top_next;
    status_t           res_st_reg, res_st_next;
    logic              res_fin_reg, res_fin_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   out_top_reg;
    logic [DEPTH_W-1:0]  out_depth_reg;
    status_t             out_st_reg;
    logic                out_fin_reg;
    logic                out_load;

    // stack ram
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [DATA_W-1:0] ram_rdata;
    logic [CNT_W-1:0]  below_cnt;
    logic [ADDR_W-1:0] below_addr;
    logic [ADDR_W-1:0] push_addr;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic              in_take;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign below_cnt  = cnt_reg - CNT_W'(2);
    assign below_addr = below_cnt[ADDR_W-1:0];
    assign push_addr  = cnt_reg[ADDR_W-1:0];
    assign out_load   = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    rpn_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (below_addr),
        .rdata (ram_rdata)
    );

    rpn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        top_next     = top_reg;
        act_next     = act_reg;
        opnd_next    = opnd_reg;
        code_next    = code_reg;
        r_next       = r_reg;
        res_top_next = res_top_reg;
        res_st_next  = res_st_reg;
        res_fin_next = res_fin_reg;
        ram_we       = 1'b0;
        ram_waddr    = push_addr;
        ram_wdata    = opnd_reg;
        ram_re       = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = ram_rdata;
        div_req.den   = top_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    act_next   = action_t'(action);
                    opnd_next  = operand;
                    code_next  = op_t'(operator_code);
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                res_st_next  = ST_OK;
                res_fin_next = 1'b0;
                res_top_next = top_reg;
                state_next   = S_OUT;
                case (act_reg)
                    ACT_PUSH:
                    begin
                        if (cnt_reg == CNT_W'(STACK_DEPTH))
                        begin
                            res_st_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            ram_we       = 1'b1;
                            cnt_next     = cnt_reg + CNT_W'(1);
                            top_next     = opnd_reg;
                            res_top_next = opnd_reg;
                        end
                    end
                    ACT_OP:
                    begin
                        if (cnt_reg < CNT_W'(2))
                        begin
                            res_st_next = ST_UNDERFLOW;
                        end
                        else
                        begin
                            // fetch b, the entry under the cached top
                            ram_re     = 1'b1;
                            state_next = S_EXEC;
                        end
                    end
                    ACT_END:
                    begin
                        res_fin_next = 1'b1;
                        cnt_next     = '0;
                        top_next     = '0;
                        if (cnt_reg == CNT_W'(1))
                        begin
                            res_top_next = top_reg;
                        end
                        else
                        begin
                            res_top_next = '0;
                            res_st_next  = ST_MALFORMED;
                        end
                    end
                    default:
                    begin
                        // unused action: report current top and depth
                        res_top_next = top_reg;
                    end
                endcase
            end
            S_EXEC:
            begin
                state_next = S_WB;
                case (code_reg)
                    OP_ADD:
                    begin
                        r_next = ram_rdata + top_reg;
                    end
                    OP_SUB:
                    begin
                        r_next = ram_rdata - top_reg;
                    end
                    OP_MUL:
                    begin
                        r_next = ram_rdata * top_reg;
                    end
                    default:
                    begin
                        if (top_reg == '0)
                        begin
                            res_st_next  = ST_DIVZERO;
                            res_top_next = top_reg;
                            state_next   = S_OUT;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    r_next     = div_rsp.quot;
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                // result replaces b, the stack shrinks by one
                ram_we       = 1'b1;
                ram_waddr    = below_addr;
                ram_wdata    = r_reg;
                cnt_next     = cnt_reg - CNT_W'(1);
                top_next     = r_reg;
                res_top_next = r_reg;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        opnd_reg    <= opnd_next;
        code_reg    <= code_next;
        r_reg       <= r_next;
        res_top_reg <= res_top_next;
        res_st_reg  <= res_st_next;
        res_fin_reg <= res_fin_next;
        if (out_load)
        begin
            out_top_reg   <= res_top_reg;
            out_depth_reg <= DEPTH_W'(cnt_reg);
            out_st_reg    <= res_st_reg;
            out_fin_reg   <= res_fin_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign top_value = out_top_reg;
    assign depth     = out_depth_reg;
    assign status    = out_st_reg;
    assign final_res = out_fin_reg;

    // stack count never goes past the configured depth
    `RPN_ASSERT_IMPLY(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(STACK_DEPTH), "stack count over depth")
    // an accepted request always starts the sequencer
    `RPN_ASSERT_NEXT(a_take_busy, clk, rst_n, in_take, state_reg == S_DECODE, "accepted request not decoded")
    // divider is never started with a zero divisor
    `RPN_ASSERT_IMPLY(a_div_nonzero, clk, rst_n, div_req.start, div_req.den != '0, "divide started on zero")
    // an end result always reports an empty stack
    `RPN_ASSERT_IMPLY(a_end_empty, clk, rst_n, out_valid && final_res, depth == '0, "end result with entries left")

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the rpn stack calculator: directed and random requests,
// a scoreboard class that predicts every result, and random idling on both channels
// depends on rpn_pkg and rpn_stack_calculator
`timescale 1ns / 1ps

module tb_top;
    import rpn_pkg::*;

    localparam int unsigned STACK_N      = DEF_STACK_DEPTH;
    localparam int unsigned ITEM_TARGET  = 1500;
    // idling on both sides stops for the last stretch of requests
    localparam int unsigned CALM_AFTER   = 1300;
    localparam int unsigned PAUSE_EVERY  = 400;
    // divide is the slowest path, so drain a bit longer
    localparam int unsigned DRAIN_CYCLES = 60;
    // enough for about 1600 requests each on the slowest path, several times over
    localparam int unsigned CYCLE_LIMIT  = 500000;

    typedef struct {
        logic [DATA_W-1:0]  top;
        logic [DEPTH_W-1:0] depth;
        status_t            status;
        logic               fin;
    } calc_result_t;

    // predicts one result per request and checks results in order
    class rpn_scoreboard;
        calc_result_t      pending_results[$];
        logic [DATA_W-1:0] stack_mem [STACK_N];
        int unsigned       stack_len;
        int unsigned       errors;
        int unsigned       checked;
        int unsigned       ends;
        int unsigned       status_seen [8];

        function new();
            stack_len = 0;
            errors    = 0;
            checked   = 0;
            ends      = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int unsigned depth_now();
            return stack_len;
        endfunction

        function int unsigned pending_count();
            return pending_results.size();
        endfunction

        function void note_request(action_t act, logic [DATA_W-1:0] opnd, op_t code);
            calc_result_t      r;
            logic [DATA_W-1:0] a;
            logic [DATA_W-1:0] b;
            logic [DATA_W-1:0] mag_a;
            logic [DATA_W-1:0] mag_b;
            logic [DATA_W-1:0] quot;
            logic [DATA_W-1:0] res;
            r.status = ST_OK;
            r.fin    = 1'b0;
            r.top    = '0;
            case (act)
                ACT_PUSH:
                begin
                    if (stack_len >= STACK_N)
                        r.status = ST_OVERFLOW;
                    else
                    begin
                        stack_mem[stack_len] = opnd;
                        stack_len++;
                    end
                end
                ACT_OP:
                begin
                    if (stack_len < 2)
                        r.status = ST_UNDERFLOW;
                    else
                    begin
                        a = stack_mem[stack_len-1];
                        b = stack_mem[stack_len-2];
                        res = '0;
                        case (code)
                            OP_ADD: res = b + a;
                            OP_SUB: res = b - a;
                            OP_MUL: res = b * a;
                            default:
                            begin
                                // truncating divide on magnitudes, sign fixed after
                                mag_a = a[DATA_W-1] ? (32'd0 - a) : a;
                                mag_b = b[DATA_W-1] ? (32'd0 - b) : b;
                                if (a != '0)
                                begin
                                    quot = mag_b / mag_a;
                                    res  = (a[DATA_W-1] ^ b[DATA_W-1]) ? (32'd0 - quot) : quot;
                                end
                            end
                        endcase
                        if (code == OP_DIV && a == '0)
                            r.status = ST_DIVZERO;
                        else
                        begin
                            stack_len--;
                            stack_mem[stack_len-1] = res;
                        end
                    end
                end
                ACT_END:
                begin
                    if (stack_len == 1)
                        r.top = stack_mem[0];
                    else
                        r.status = ST_MALFORMED;
                    stack_len = 0;
                    r.fin = 1'b1;
                    ends++;
                end
                default: ;
            endcase
            if (act != ACT_END)
                r.top = (stack_len == 0) ? '0 : stack_mem[stack_len-1];
            r.depth = stack_len[DEPTH_W-1:0];
            status_seen[int'(r.status)]++;
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [DATA_W-1:0] top, logic [DEPTH_W-1:0] dep,
                                   logic [STATUS_W-1:0] st, logic fin);
            calc_result_t exp_r;
            checked++;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: top %0d depth %0d status %0d final %0b",
                             $signed(top), dep, st, fin);
                return;
            end
            exp_r = pending_results.pop_front();
            if (top !== exp_r.top || dep !== exp_r.depth || st !== exp_r.status
                || fin !== exp_r.fin)
            begin
                errors++;
                if (errors <= 10)
                    $display("result %0d: expected top %0d depth %0d status %0d final %0b, %s",
                             checked, $signed(exp_r.top), exp_r.depth, exp_r.status,
                             exp_r.fin,
                             $sformatf("got top %0d depth %0d status %0d final %0b",
                                       $signed(top), dep, st, fin));
            end
        endfunction
    endclass

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // request channel
    logic                        in_valid      = 1'b0;
    logic                        in_stall;
    logic [1:0]                  action        = ACT_NONE;
    logic signed [DATA_W-1:0]    operand       = '0;
    logic [1:0]                  operator_code = OP_ADD;

    // result channel
    logic                        out_valid;
    logic                        out_stall     = 1'b0;
    logic signed [DATA_W-1:0]    top_value;
    logic [DEPTH_W-1:0]          depth;
    logic [STATUS_W-1:0]         status;
    logic                        final_res;

    // test control
    logic          calm         = 1'b0;
    bit            sender_idles = 1'b0;
    int unsigned   sent_count   = 0;
    int unsigned   cycles       = 0;
    int unsigned   stall_left   = 0;
    int unsigned   quiet_left   = 0;
    rpn_scoreboard sb;

    rpn_stack_calculator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .operand       (operand),
        .operator_code (operator_code),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .top_value     (top_value),
        .depth         (depth),
        .status        (status),
        .final_res     (final_res)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // reset held low at the start, then released once for the whole run
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycles, sb.pending_count());
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stall bursts, quiet stretches, none in the calm tail
    always @(posedge clk)
    begin
        if (!rst_n || calm)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (quiet_left > 0)
        begin
            out_stall <= 1'b0;
            quiet_left--;
        end
        else
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    out_stall  <= 1'b1;
                    stall_left = $urandom_range(1, 6) - 1;
                end
                2:
                begin
                    out_stall  <= 1'b0;
                    quiet_left = $urandom_range(20, 80);
                end
                default: out_stall <= 1'b0;
            endcase
        end
    end

    // result monitor, samples values from before the edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(top_value, depth, status, final_res);
    end

    // operand mix: extremes, small values (zero divisors among them) and full range
    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'd1;
            2:       return '1;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h8000_0000;
            5, 6:    return $urandom_range(0, 40) - 32'd20;
            default: return $urandom();
        endcase
    endfunction

    // drive one request, hold it until accepted, then maybe idle before the next one
    task automatic send_request(action_t act, logic [DATA_W-1:0] opnd, op_t code);
        int unsigned gap;
        in_valid      <= 1'b1;
        action        <= act;
        operand       <= opnd;
        operator_code <= code;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(act, opnd, code);
        if (act != ACT_NONE)
            sent_count++;
        if (!calm && sender_idles && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender holds off until every predicted result has come back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending_count() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // mostly well-formed expression with random content; a few are cut short
    task automatic run_expression(int unsigned max_push);
        int unsigned pushes_left;
        int unsigned guard;
        pushes_left = $urandom_range(1, max_push);
        guard = 0;
        while ((pushes_left > 0 || sb.depth_now() > 1) && guard < 200)
        begin
            if ($urandom_range(0, 59) == 0)
                break;
            if (sb.depth_now() < 2 || (pushes_left > 0 && $urandom_range(0, 1) == 0))
            begin
                send_request(ACT_PUSH, pick_operand(), op_t'($urandom_range(0, 3)));
                if (pushes_left > 0)
                    pushes_left--;
            end
            else
                send_request(ACT_OP, $urandom(), op_t'($urandom_range(0, 3)));
            guard++;
        end
        send_request(ACT_END, $urandom(), op_t'($urandom_range(0, 3)));
    endtask

    initial
    begin
        int unsigned next_pause;
        int unsigned sel;
        int unsigned n;

        sb = new();
        @(posedge rst_n);
        @(posedge clk);

        // directed: empty-stack faults, wrap on add, most negative over minus one,
        // divide by zero, truncation toward zero, ignored action, malformed end
        sender_idles = 1'b1;
        send_request(ACT_END,  32'd0,         OP_ADD);
        send_request(ACT_OP,   32'd0,         OP_ADD);
        send_request(ACT_PUSH, 32'h7FFF_FFFF, OP_ADD);
        send_request(ACT_OP,   32'd0,         OP_SUB);
        send_request(ACT_PUSH, 32'd1,         OP_ADD);
        send_request(ACT_OP,   32'd0,         OP_ADD);
        send_request(ACT_PUSH, 32'hFFFF_FFFF, OP_ADD);
        send_request(ACT_OP,   32'd0,         OP_DIV);
        send_request(ACT_PUSH, 32'd0,         OP_ADD);
        send_request(ACT_OP,   32'd0,         OP_DIV);
        send_request(ACT_OP,   32'd0,         OP_MUL);
        send_request(ACT_PUSH, -32'sd7,       OP_ADD);
        send_request(ACT_PUSH, 32'd2,         OP_ADD);
        send_request(ACT_OP,   32'd0,         OP_DIV);
        send_request(ACT_OP,   32'd0,         OP_SUB);
        send_request(ACT_NONE, 32'hFFFF_FFFF, OP_DIV);
        send_request(ACT_PUSH, 32'h8000_0000, OP_ADD);
        send_request(ACT_END,  32'd0,         OP_ADD);
        send_request(ACT_PUSH, 32'hFFFF_FFFF, OP_ADD);
        send_request(ACT_PUSH, 32'hFFFF_FFFF, OP_ADD);
        send_request(ACT_OP,   32'd0,         OP_MUL);
        send_request(ACT_END,  32'd0,         OP_ADD);
        wait_for_drain();

        // random: mostly expressions, some deep enough to overflow, some noise
        next_pause = PAUSE_EVERY;
        while (sent_count < ITEM_TARGET)
        begin
            if (sent_count >= CALM_AFTER)
                calm <= 1'b1;
            sender_idles = ($urandom_range(0, 3) != 0);
            sel = $urandom_range(0, 19);
            if (sel < 14)
                run_expression(6);
            else if (sel < 17)
                run_expression(20);
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    send_request(action_t'($urandom_range(0, 3)), pick_operand(),
                                 op_t'($urandom_range(0, 3)));
            end
            if (sent_count >= next_pause)
            begin
                wait_for_drain();
                next_pause += PAUSE_EVERY;
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d requests, %0d results checked, %0d expressions ended (%0d malformed)",
                 sent_count, sb.checked, sb.ends, sb.status_seen[int'(ST_MALFORMED)]);
        $display("faults hit: %0d overflow, %0d underflow, %0d divide by zero",
                 sb.status_seen[int'(ST_OVERFLOW)], sb.status_seen[int'(ST_UNDERFLOW)],
                 sb.status_seen[int'(ST_DIVZERO)]);
        if (sb.errors == 0 && sb.pending_count() == 0)
            $display("No mismatches found");
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending_count());
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* rpn_stack_calculator.f */
+incdir+design
design/rpn_pkg.sv
design/rpn_ram.sv
design/rpn_div.sv
design/rpn_stack_calculator.sv
tb/tb_top.sv
